>>> design/quaternion_to_euler_angles_macros.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by the port checker; depends on nothing else.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// implication checked outside reset
`define Q2E_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q2e check failed");

// next-cycle implication checked outside reset
`define Q2E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q2e check failed");

// next-cycle implication that also holds through reset
`define Q2E_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("q2e check failed");

`endif

>>> design/q2e_pkg.sv
// Shared types, constants and CORDIC / square-root step functions
// for the quaternion to Euler angle converter. No dependencies.
package q2e_pkg;

   localparam int Q14W      = 16;
   localparam int PRODW     = 32;
   localparam int SUMW      = 34;
   localparam int SW        = 30;
   localparam int CW        = 40;
   localparam int AW        = 25;
   localparam int VW        = 58;
   localparam int ISQ_STEPS = 29;
   localparam int SQW       = 29;
   localparam int TABLE_LEN = 24;
   localparam int HALF_TURN = 180 * 32768;
   localparam int YAW_LIM   = 23040;
   localparam int PITCH_LIM = 11520;

   localparam logic signed [SW-1:0] ONE_Q28 = SW'(1 << 28);
   localparam logic [VW-1:0]        ONE_Q56 = VW'(1) << 56;

   typedef struct packed {
      logic signed [SUMW-1:0] yaw_y;
      logic signed [SUMW-1:0] yaw_x;
      logic signed [SUMW-1:0] roll_y;
      logic signed [SUMW-1:0] roll_x;
      logic signed [SW-1:0]   s;
      logic                   clamped;
   } item_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] z;
      logic                 zero;
   } vec_type;

   typedef struct packed {
      vec_type         yaw;
      vec_type         roll;
      vec_type         pitch;
      logic [VW-1:0]   v;
      logic [VW-1:0]   res;
      logic            clamped;
   } stage_type;

   function automatic logic signed [AW-1:0] atan_tab(input int i);
      logic signed [AW-1:0] a;
      case (i)
         0:  a = AW'(1474560);
         1:  a = AW'(870484);
         2:  a = AW'(459940);
         3:  a = AW'(233473);
         4:  a = AW'(117189);
         5:  a = AW'(58652);
         6:  a = AW'(29333);
         7:  a = AW'(14667);
         8:  a = AW'(7334);
         9:  a = AW'(3667);
         10: a = AW'(1833);
         11: a = AW'(917);
         12: a = AW'(458);
         13: a = AW'(229);
         14: a = AW'(115);
         15: a = AW'(57);
         16: a = AW'(29);
         17: a = AW'(14);
         18: a = AW'(7);
         19: a = AW'(4);
         20: a = AW'(2);
         21: a = AW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

   // half-turn pre-rotation into the right half-plane, zero vector flagged
   function automatic vec_type cordic_pre(input vec_type a);
      vec_type r;
      r      = a;
      r.z    = '0;
      r.zero = (a.x == '0) && (a.y == '0);
      if (a.x < 0) begin
         r.x = -a.x;
         r.y = -a.y;
         r.z = (a.y >= 0) ? AW'(HALF_TURN) : -AW'(HALF_TURN);
      end
      return r;
   endfunction

   function automatic vec_type cordic_step(input vec_type a, input int i);
      vec_type r;
      r = a;
      if (a.y >= 0) begin
         r.x = a.x + (a.y >>> i);
         r.y = a.y - (a.x >>> i);
         r.z = a.z + atan_tab(i);
      end else begin
         r.x = a.x - (a.y >>> i);
         r.y = a.y + (a.x >>> i);
         r.z = a.z - atan_tab(i);
      end
      return r;
   endfunction

   function automatic stage_type isqrt_step(input stage_type a, input int k);
      stage_type     r;
      logic [VW-1:0] b;
      logic [VW-1:0] t;
      r = a;
      b = VW'(1) << (56 - 2 * k);
      t = a.res + b;
      if (a.v >= t) begin
         r.v   = a.v - t;
         r.res = (a.res >> 1) + b;
      end else begin
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_deg(input logic signed [AW-1:0] z,
                                                input int lim, input logic zero);
      logic signed [AW-1:0] r;
      r = (z + AW'(128)) >>> 8;
      if (zero) r = '0;
      if (r > AW'(lim)) r = AW'(lim);
      if (r < -AW'(lim)) r = -AW'(lim);
      return r[15:0];
   endfunction

endpackage

>>> design/q2e_front.sv
// Front end: rescales the quaternion to Q2.14, forms the products and
// the atan2 / arcsine operands with clamp. Uses q2e_pkg.
module q2e_front #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic signed [QUAT_WIDTH-1:0] in_w,
   input  logic signed [QUAT_WIDTH-1:0] in_x,
   input  logic signed [QUAT_WIDTH-1:0] in_y,
   input  logic signed [QUAT_WIDTH-1:0] in_z,
   output logic                         out_valid,
   input  logic                         out_full,
   output q2e_pkg::item_type            out_item
);

   logic signed [q2e_pkg::Q14W-1:0] qw, qx, qy, qz;
   logic signed [q2e_pkg::Q14W-1:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [q2e_pkg::PRODW-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [q2e_pkg::PRODW-1:0] xy_ff, wz_ff, wx_ff, yz_ff, xz_ff, wy_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic enable;
   q2e_pkg::item_type item_ff, item_in;
   logic signed [q2e_pkg::SUMW-1:0] s_raw;

   generate
      if (QUAT_WIDTH >= 16) begin : g_down
         assign qw = q2e_pkg::Q14W'(in_w >>> (QUAT_WIDTH - 16));
         assign qx = q2e_pkg::Q14W'(in_x >>> (QUAT_WIDTH - 16));
         assign qy = q2e_pkg::Q14W'(in_y >>> (QUAT_WIDTH - 16));
         assign qz = q2e_pkg::Q14W'(in_z >>> (QUAT_WIDTH - 16));
      end else begin : g_up
         assign qw = {in_w, {(16 - QUAT_WIDTH){1'b0}}};
         assign qx = {in_x, {(16 - QUAT_WIDTH){1'b0}}};
         assign qy = {in_y, {(16 - QUAT_WIDTH){1'b0}}};
         assign qz = {in_z, {(16 - QUAT_WIDTH){1'b0}}};
      end
   endgenerate

   assign enable   = !(v3_ff && out_full);
   assign in_stall = !enable;

   always_comb begin
      item_in.yaw_y  = 2 * (q2e_pkg::SUMW'(xy_ff) + q2e_pkg::SUMW'(wz_ff));
      item_in.yaw_x  = q2e_pkg::SUMW'(ww_ff) + q2e_pkg::SUMW'(xx_ff)
                     - q2e_pkg::SUMW'(yy_ff) - q2e_pkg::SUMW'(zz_ff);
      item_in.roll_y = 2 * (q2e_pkg::SUMW'(wx_ff) + q2e_pkg::SUMW'(yz_ff));
      item_in.roll_x = q2e_pkg::SUMW'(ww_ff) - q2e_pkg::SUMW'(xx_ff)
                     - q2e_pkg::SUMW'(yy_ff) + q2e_pkg::SUMW'(zz_ff);
      s_raw          = 2 * (q2e_pkg::SUMW'(xz_ff) - q2e_pkg::SUMW'(wy_ff));
      item_in.clamped = 1'b0;
      if (s_raw > q2e_pkg::SUMW'(q2e_pkg::ONE_Q28)) begin
         item_in.s       = q2e_pkg::ONE_Q28;
         item_in.clamped = 1'b1;
      end else if (s_raw < -q2e_pkg::SUMW'(q2e_pkg::ONE_Q28)) begin
         item_in.s       = -q2e_pkg::ONE_Q28;
         item_in.clamped = 1'b1;
      end else begin
         item_in.s = q2e_pkg::SW'(s_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (enable) begin
         w_ff    <= qw;
         x_ff    <= qx;
         y_ff    <= qy;
         z_ff    <= qz;
         ww_ff   <= w_ff * w_ff;
         xx_ff   <= x_ff * x_ff;
         yy_ff   <= y_ff * y_ff;
         zz_ff   <= z_ff * z_ff;
         xy_ff   <= x_ff * y_ff;
         wz_ff   <= w_ff * z_ff;
         wx_ff   <= w_ff * x_ff;
         yz_ff   <= y_ff * z_ff;
         xz_ff   <= x_ff * z_ff;
         wy_ff   <= w_ff * y_ff;
         item_ff <= item_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item_ff;

endmodule

>>> design/q2e_fifo.sv
// Four-entry item queue between front and back ends. Uses q2e_pkg.
module q2e_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q2e_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output q2e_pkg::item_type head
);

   q2e_pkg::item_type mem [0:3];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign full      = (cnt_ff == 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign head      = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem[wr_ff] <= push_item;
   end

endmodule

>>> design/q2e_back.sv
// Back end: square root for the arcsine cosine term, then three parallel
// pipelined CORDIC vectoring units and angle scaling. Uses q2e_pkg.
module q2e_back #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_avail,
   input  q2e_pkg::item_type       in_item,
   output logic                    in_pop,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [15:0]      out_yaw,
   output logic signed [14:0]      out_pitch,
   output logic signed [15:0]      out_roll,
   output logic                    out_clamped
);

   localparam int NSTG = (CORDIC_STAGES < q2e_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : q2e_pkg::TABLE_LEN;
   localparam int PRE  = 1 + q2e_pkg::ISQ_STEPS;
   localparam int NST  = PRE + 1 + NSTG;

   q2e_pkg::stage_type st_ff [0:NST-1];
   q2e_pkg::stage_type st_in [0:NST-1];
   logic               vld_ff [0:NST-1];
   logic               enable;
   logic               rsp_valid_ff;
   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;
   logic               clamped_ff;
   logic [q2e_pkg::SQW-1:0] s_abs;
   logic [2*q2e_pkg::SQW-1:0] s_sq;
   logic signed [15:0] pitch_w;

   assign enable = !(rsp_valid_ff && out_stall);
   assign in_pop = in_avail && enable;
   assign s_abs  = q2e_pkg::SQW'(in_item.s < 0 ? -in_item.s : in_item.s);
   assign s_sq   = s_abs * s_abs;

   always_comb begin
      st_in[0].yaw.x    = q2e_pkg::CW'(in_item.yaw_x);
      st_in[0].yaw.y    = q2e_pkg::CW'(in_item.yaw_y);
      st_in[0].yaw.z    = '0;
      st_in[0].yaw.zero = 1'b0;
      st_in[0].roll.x    = q2e_pkg::CW'(in_item.roll_x);
      st_in[0].roll.y    = q2e_pkg::CW'(in_item.roll_y);
      st_in[0].roll.z    = '0;
      st_in[0].roll.zero = 1'b0;
      st_in[0].pitch.x    = '0;
      st_in[0].pitch.y    = q2e_pkg::CW'(in_item.s);
      st_in[0].pitch.z    = '0;
      st_in[0].pitch.zero = 1'b0;
      st_in[0].v       = q2e_pkg::ONE_Q56 - q2e_pkg::VW'(s_sq);
      st_in[0].res     = '0;
      st_in[0].clamped = in_item.clamped;
   end

   genvar k;
   generate
      for (k = 1; k < NST; k++) begin : g_stage
         if (k < PRE) begin : g_isq
            assign st_in[k] = q2e_pkg::isqrt_step(st_ff[k-1], k - 1);
         end else if (k == PRE) begin : g_pre
            q2e_pkg::stage_type p;
            always_comb begin
               p         = st_ff[k-1];
               p.pitch.x = q2e_pkg::CW'(st_ff[k-1].res);
               st_in[k]       = p;
               st_in[k].yaw   = q2e_pkg::cordic_pre(p.yaw);
               st_in[k].roll  = q2e_pkg::cordic_pre(p.roll);
               st_in[k].pitch = q2e_pkg::cordic_pre(p.pitch);
            end
         end else begin : g_rot
            always_comb begin
               st_in[k]       = st_ff[k-1];
               st_in[k].yaw   = q2e_pkg::cordic_step(st_ff[k-1].yaw, k - PRE - 1);
               st_in[k].roll  = q2e_pkg::cordic_step(st_ff[k-1].roll, k - PRE - 1);
               st_in[k].pitch = q2e_pkg::cordic_step(st_ff[k-1].pitch, k - PRE - 1);
            end
         end
      end
   endgenerate

   assign pitch_w = q2e_pkg::to_deg(st_ff[NST-1].pitch.z, q2e_pkg::PITCH_LIM,
                                    st_ff[NST-1].pitch.zero);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_pop;
         for (int i = 1; i < NST; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[NST-1];
      end
      if (enable) begin
         for (int i = 0; i < NST; i++) st_ff[i] <= st_in[i];
         yaw_ff     <= q2e_pkg::to_deg(st_ff[NST-1].yaw.z, q2e_pkg::YAW_LIM,
                                       st_ff[NST-1].yaw.zero);
         roll_ff    <= -q2e_pkg::to_deg(st_ff[NST-1].roll.z, q2e_pkg::YAW_LIM,
                                        st_ff[NST-1].roll.zero);
         pitch_ff   <= 15'(-pitch_w);
         clamped_ff <= st_ff[NST-1].clamped;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_yaw     = yaw_ff;
   assign out_pitch   = pitch_ff;
   assign out_roll    = roll_ff;
   assign out_clamped = clamped_ff;

endmodule

>>> design/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle (Z-Y-X) converter.
// Instantiates q2e_front, q2e_fifo and q2e_back; uses q2e_pkg.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | quat w, x, y, z
//   rsp     | out       | rsp_valid/stall  | yaw, pitch, roll, pitch_clamped
//
// One item per cycle sustained while no result is stalled; an item passes the front
// end registers, the queue, then the back end (square root iterations and CORDIC stages).
// Reset clears the valid bits and the queue pointers and count only.
// A stalled result halts the back end; the four-item queue lets the front
// end keep accepting until it fills.
module quaternion_to_euler_angles #(
   parameter int QUAT_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_w,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_yaw_deg,
   output logic signed [14:0]           rsp_pitch_deg,
   output logic signed [15:0]           rsp_roll_deg,
   output logic                         rsp_pitch_clamped
);

   q2e_pkg::item_type front_item, head_item;
   logic front_valid, q_full, q_avail, q_pop, q_push;

   assign q_push = front_valid && !q_full;

   q2e_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_w     (req_quat_w),
      .in_x     (req_quat_x),
      .in_y     (req_quat_y),
      .in_z     (req_quat_z),
      .out_valid(front_valid),
      .out_full (q_full),
      .out_item (front_item)
   );

   q2e_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(front_item),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_avail),
      .head     (head_item)
   );

   q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_avail   (q_avail),
      .in_item    (head_item),
      .in_pop     (q_pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_yaw    (rsp_yaw_deg),
      .out_pitch  (rsp_pitch_deg),
      .out_roll   (rsp_roll_deg),
      .out_clamped(rsp_pitch_clamped)
   );

endmodule

>>> design/q2e_checker.sv
// Port-level checks for the quaternion to Euler angle converter, bound
// to the top level. Uses quaternion_to_euler_angles_macros.svh.
`include "quaternion_to_euler_angles_macros.svh"

module q2e_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [15:0] rsp_yaw_deg,
   input logic signed [14:0] rsp_pitch_deg,
   input logic signed [15:0] rsp_roll_deg
);

   `Q2E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `Q2E_ASSERT_ALWAYS_NEXT(a_reset_clear, clock, reset, !rsp_valid)
   `Q2E_ASSERT_IMPL(a_pitch_range, clock, reset, rsp_valid, rsp_pitch_deg <= 15'sd11520 && rsp_pitch_deg >= -15'sd11520)
   `Q2E_ASSERT_IMPL(a_yaw_range, clock, reset, rsp_valid, rsp_yaw_deg <= 16'sd23040 && rsp_yaw_deg >= -16'sd23040)
   `Q2E_ASSERT_IMPL(a_roll_range, clock, reset, rsp_valid, rsp_roll_deg <= 16'sd23040 && rsp_roll_deg >= -16'sd23040)

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_yaw_deg  (rsp_yaw_deg),
   .rsp_pitch_deg(rsp_pitch_deg),
   .rsp_roll_deg (rsp_roll_deg)
);
